FILE: hw/rtl/ts_packet_continuity_monitor_unit_assert.svh
// Assertion helpers for the continuity monitor.
// Each macro expects clk_i and rst_ni in scope.
`ifndef TS_PACKET_CONTINUITY_MONITOR_UNIT_ASSERT_SVH
`define TS_PACKET_CONTINUITY_MONITOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TPCM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tpcm assertion failed");

// Next-cycle implication.
`define TPCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tpcm assertion failed");

`endif

FILE: hw/rtl/tpcm_pkg.sv
package tpcm_pkg;

  // PID table geometry
  localparam int unsigned PidEntries = 8192;
  localparam int unsigned PidW       = $clog2(PidEntries);
  localparam int unsigned CcW        = 4;
  localparam int unsigned EntryW     = CcW + 1;
  localparam int unsigned CntW       = 32;

  // Header constants
  localparam logic [7:0]      SyncByte   = 8'h47;
  localparam logic [PidW-1:0] NullPid    = '1;
  localparam logic            ModeReport = 1'b1;

  typedef logic [7:0]      hbyte_t;
  typedef logic [PidW-1:0] pid_t;
  typedef logic [CcW-1:0]  cc_t;
  typedef logic [CntW-1:0] cnt_t;

  // Table entry: seen flag plus expected next counter
  typedef struct packed {
    logic seen;
    cc_t  next_cc;
  } entry_t;

  // Header fields pre-decoded at accept time
  typedef struct packed {
    logic report;
    logic sync_ok;
    logic is_null;
    logic tei;
    logic scr;
    cc_t  cc;
    pid_t pid;
  } hdr_t;

endpackage

FILE: hw/rtl/tpcm_ifs.sv
// Header channel
interface tpcm_in_if import tpcm_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   mode;
  hbyte_t sync_byte;
  hbyte_t header_byte1;
  hbyte_t header_byte2;
  hbyte_t header_byte3;

  modport source (output valid, mode, sync_byte, header_byte1, header_byte2, header_byte3,
                  input ready);
  modport sink   (input valid, mode, sync_byte, header_byte1, header_byte2, header_byte3,
                  output ready);
endinterface

// Statistics channel
interface tpcm_out_if import tpcm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cc_error;
  logic              new_pid;
  cnt_t              error_total;
  cnt_t              scrambled_total;
  cnt_t              tei_total;
  cnt_t              packet_total;
  logic [PidW-1:0]   pid_total;
  cnt_t              null_total;
  logic              sync_lost;

  modport source (output valid, cc_error, new_pid, error_total, scrambled_total, tei_total,
                         packet_total, pid_total, null_total, sync_lost,
                  input ready);
  modport sink   (input valid, cc_error, new_pid, error_total, scrambled_total, tei_total,
                        packet_total, pid_total, null_total, sync_lost,
                  output ready);
endinterface

FILE: hw/rtl/tpcm_ram.sv
// Simple dual-port RAM, registered read, read returns old data on collision
module tpcm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/ts_packet_continuity_monitor_unit.sv
// Transport stream continuity monitor. Takes one four-byte packet header (or a
// report request) per beat on in_i and returns one statistics beat on out_o for
// each. Sustained rate is one header per clock while out_o does not stall, also
// for back-to-back headers on the same PID; a header passes through stage 1 and
// then the output register before out_o valid. The rate is set by the per-PID
// table, an 8192 x 5 RAM that is read when a header is accepted and written back
// when it leaves stage 1, with a forwarding register covering a write and a read
// of the same PID in the same cycle. After reset the table is cleared one entry
// per cycle, so in_i.ready stays low until the table is clear. A report beat
// returns the totals and then zeroes all of them except pid_total and sync_lost.
`include "ts_packet_continuity_monitor_unit_assert.svh"

module ts_packet_continuity_monitor_unit import tpcm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tpcm_in_if.sink    in_i,
  tpcm_out_if.source out_o
);

  // Table clearing pass
  logic clearing_q, clearing_d;
  pid_t clr_q, clr_d;

  // Stage 1 (table read outstanding)
  logic   s1_valid_q, s1_valid_d;
  hdr_t   s1_q;
  logic   fwd_hit_q;
  entry_t fwd_data_q;

  // Statistics
  cnt_t err_q, err_d, scr_q, scr_d, tei_q, tei_d, pkt_q, pkt_d, nul_q, nul_d;
  pid_t pidc_q, pidc_d;
  logic sync_q, sync_d;

  // Output register
  logic out_valid_q, out_valid_d;

  // Handshake and table port
  logic   in_acc, s1_adv;
  hdr_t   in_hdr;
  logic   ram_we;
  pid_t   ram_waddr;
  entry_t ram_wdata, ram_rdata, cur_entry;
  logic   check, fresh, cc_bad;
  cc_t    cc_prev;

  // Decode incoming header
  always_comb begin
    in_hdr.report  = (in_i.mode == ModeReport);
    in_hdr.sync_ok = (in_i.sync_byte == SyncByte);
    in_hdr.pid     = {in_i.header_byte1[4:0], in_i.header_byte2};
    in_hdr.is_null = (in_hdr.pid == NullPid);
    in_hdr.tei     = in_i.header_byte1[7];
    in_hdr.scr     = in_i.header_byte3[7];
    in_hdr.cc      = in_i.header_byte3[CcW-1:0];
  end

  assign s1_adv      = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !clearing_q && (!s1_valid_q || s1_adv);
  assign in_acc      = in_i.valid && in_i.ready;
  assign s1_valid_d  = in_acc || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && !out_o.ready);

  // Continuity check against the (possibly forwarded) table entry
  always_comb begin
    cur_entry = fwd_hit_q ? fwd_data_q : ram_rdata;
    check     = !s1_q.report && s1_q.sync_ok && !s1_q.is_null;
    cc_prev   = cur_entry.next_cc - cc_t'(1);
    fresh     = check && !cur_entry.seen;
    cc_bad    = check && cur_entry.seen && (s1_q.cc != cur_entry.next_cc) &&
                (s1_q.cc != cc_prev);
  end

  // Table write port: clearing pass or write-back
  always_comb begin
    if (clearing_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else begin
      ram_we            = s1_adv && check;
      ram_waddr         = s1_q.pid;
      ram_wdata.seen    = 1'b1;
      ram_wdata.next_cc = s1_q.cc + cc_t'(1);
    end
  end

  // Clearing pass sequencing
  always_comb begin
    clr_d      = clr_q + pid_t'(1);
    clearing_d = clearing_q && (clr_q != pid_t'(PidEntries - 1));
  end

  // Statistics update when stage 1 moves to the output register
  always_comb begin
    err_d  = err_q;
    scr_d  = scr_q;
    tei_d  = tei_q;
    pkt_d  = pkt_q;
    nul_d  = nul_q;
    pidc_d = pidc_q;
    sync_d = sync_q;
    if (s1_adv) begin
      if (s1_q.report) begin
        err_d = '0;
        scr_d = '0;
        tei_d = '0;
        pkt_d = '0;
        nul_d = '0;
      end else if (!s1_q.sync_ok) begin
        sync_d = 1'b1;
      end else begin
        pkt_d = pkt_q + cnt_t'(1);
        if (s1_q.is_null) begin
          nul_d = nul_q + cnt_t'(1);
        end else begin
          tei_d  = tei_q + cnt_t'(s1_q.tei);
          scr_d  = scr_q + cnt_t'(s1_q.scr);
          err_d  = err_q + cnt_t'(cc_bad);
          pidc_d = pidc_q + pid_t'(fresh);
        end
      end
    end
  end

  tpcm_ram #(
    .Width (EntryW),
    .Depth (PidEntries)
  ) u_cc_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (in_hdr.pid),
    .rdata_o (ram_rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      err_q       <= '0;
      scr_q       <= '0;
      tei_q       <= '0;
      pkt_q       <= '0;
      nul_q       <= '0;
      pidc_q      <= '0;
      sync_q      <= 1'b0;
    end else begin
      clearing_q  <= clearing_d;
      if (clearing_q) begin
        clr_q <= clr_d;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      err_q       <= err_d;
      scr_q       <= scr_d;
      tei_q       <= tei_d;
      pkt_q       <= pkt_d;
      nul_q       <= nul_d;
      pidc_q      <= pidc_d;
      sync_q      <= sync_d;
    end
  end

  // Stage 1 payload and forwarding of a same-cycle write
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q       <= in_hdr;
      fwd_hit_q  <= ram_we && (ram_waddr == in_hdr.pid);
      fwd_data_q <= ram_wdata;
    end
  end

  // Output beat: report shows totals before the clear, check shows them after
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_o.cc_error        <= cc_bad;
      out_o.new_pid         <= fresh;
      out_o.error_total     <= s1_q.report ? err_q : err_d;
      out_o.scrambled_total <= s1_q.report ? scr_q : scr_d;
      out_o.tei_total       <= s1_q.report ? tei_q : tei_d;
      out_o.packet_total    <= s1_q.report ? pkt_q : pkt_d;
      out_o.pid_total       <= pidc_d;
      out_o.null_total      <= s1_q.report ? nul_q : nul_d;
      out_o.sync_lost       <= sync_d;
    end
  end

  assign out_o.valid = out_valid_q;

  // Checks
  `TPCM_ASSERT_NOW(a_no_accept_clearing, clearing_q, !in_acc)
  `TPCM_ASSERT_NEXT(a_stall_holds_rdata, s1_valid_q && !s1_adv, $stable(ram_rdata))
  `TPCM_ASSERT_NEXT(a_sync_sticky, sync_q, sync_q)
  `TPCM_ASSERT_NEXT(a_pid_total_on_fresh, !(s1_adv && fresh), $stable(pidc_q))
  `TPCM_ASSERT_NOW(a_err_not_fresh, s1_valid_q && fresh, !cc_bad)

endmodule
